// File: sv/piecewise_cubic_bezier_sampler_macros.svh
// Assertion macros used by the checker file of the sampler.
`ifndef PIECEWISE_CUBIC_BEZIER_SAMPLER_MACROS_SVH
`define PIECEWISE_CUBIC_BEZIER_SAMPLER_MACROS_SVH

// Property checked at every clock edge outside reset.
`define PCBS_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Property checked at every clock edge, reset included.
`define PCBS_ASSERT_ALWAYS(label, prop, msg) \
	label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: sv/pcbs_pkg.sv
`timescale 1ns / 1ps

package pcbs_pkg;

	// Field widths of the stream words.
	localparam int COORD_W = 12;
	localparam int POINT_W = 2 * COORD_W;

	// Default number of sample intervals per segment.
	localparam int STEPS_DEF = 50;

	localparam int DEG_W   = 2;
	localparam int SEEN_W  = 3;
	localparam int PHASE_W = 2;

	localparam logic [DEG_W-1:0]   DEG_POINT  = 2'd0;
	localparam logic [DEG_W-1:0]   DEG_CUBIC  = 2'd3;
	localparam logic [SEEN_W-1:0]  SEEN_CUBIC = 3'd3;
	localparam logic [SEEN_W-1:0]  SEEN_MAX   = 3'd4;
	localparam logic [PHASE_W-1:0] PHASE_ZERO = 2'd0;
	localparam logic [PHASE_W-1:0] PHASE_LAST = 2'd2;

	typedef enum logic {
		ST_IDLE,
		ST_RUN
	} state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic             load;
		logic             push;
		logic [DEG_W-1:0] degree;
		logic             issue;
		logic             last;
		logic             done;
	} cmd_t;

endpackage

// File: sv/pcbs_ctrl.sv
`timescale 1ns / 1ps

module pcbs_ctrl #(
	parameter int STEPS = pcbs_pkg::STEPS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         s_tvalid,
	input  logic                         s_tlast,
	output logic                         s_tready,
	input  logic                         adv,
	output pcbs_pkg::cmd_t               cmd,
	output logic [$clog2(STEPS+1)-1:0]   step_k
);

	localparam int SW = $clog2(STEPS + 1);
	localparam logic [SW-1:0] STEPS_K = SW'(STEPS);

	pcbs_pkg::state_t                    state_q, state_d;
	logic [pcbs_pkg::SEEN_W-1:0]         seen_q;
	logic [pcbs_pkg::PHASE_W-1:0]        phase_q;
	logic [SW-1:0]                       k_q;
	logic                                fin_q;
	logic                                single_q;

	logic                                accept;
	logic                                emit;
	logic                                last_smp;
	logic [pcbs_pkg::DEG_W-1:0]          deg_in;

	// The input side is open exactly in the idle state.
	assign accept   = s_tvalid && (state_q == pcbs_pkg::ST_IDLE);
	assign emit     = s_tlast || ((seen_q >= pcbs_pkg::SEEN_CUBIC) &&
		(phase_q == pcbs_pkg::PHASE_ZERO));
	assign last_smp = single_q || (k_q == STEPS_K);

	// A short final curve takes the degree of its point count less one.
	always_comb begin
		if (s_tlast && (seen_q < pcbs_pkg::SEEN_CUBIC)) begin
			deg_in = seen_q[pcbs_pkg::DEG_W-1:0];
		end else begin
			deg_in = pcbs_pkg::DEG_CUBIC;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			pcbs_pkg::ST_IDLE: begin
				if (accept && emit) begin
					state_d = pcbs_pkg::ST_RUN;
				end
			end
			pcbs_pkg::ST_RUN: begin
				if (adv && last_smp) begin
					state_d = pcbs_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = pcbs_pkg::ST_IDLE;
			end
		endcase
	end

	always_comb begin
		s_tready   = 1'b0;
		cmd        = '0;
		cmd.degree = deg_in;
		cmd.last   = last_smp;
		cmd.done   = last_smp && fin_q;
		case (state_q)
			pcbs_pkg::ST_IDLE: begin
				s_tready = 1'b1;
				cmd.load = accept && emit;
				cmd.push = accept && !s_tlast;
			end
			pcbs_pkg::ST_RUN: begin
				cmd.issue = adv;
			end
			default: begin
				s_tready = 1'b0;
			end
		endcase
	end

	assign step_k = k_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= pcbs_pkg::ST_IDLE;
			seen_q   <= '0;
			phase_q  <= '0;
			k_q      <= '0;
			fin_q    <= 1'b0;
			single_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (accept) begin
				if (s_tlast) begin
					seen_q  <= '0;
					phase_q <= '0;
				end else begin
					if (seen_q < pcbs_pkg::SEEN_MAX) begin
						seen_q <= seen_q + 1'b1;
					end
					if (phase_q >= pcbs_pkg::PHASE_LAST) begin
						phase_q <= pcbs_pkg::PHASE_ZERO;
					end else begin
						phase_q <= phase_q + 1'b1;
					end
				end
			end
			if (cmd.load) begin
				k_q      <= '0;
				fin_q    <= s_tlast;
				single_q <= (deg_in == pcbs_pkg::DEG_POINT);
			end else if (cmd.issue) begin
				k_q <= k_q + 1'b1;
			end
		end
	end

endmodule

// File: sv/pcbs_datapath.sv
`timescale 1ns / 1ps

module pcbs_datapath #(
	parameter int STEPS = pcbs_pkg::STEPS_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  pcbs_pkg::cmd_t                 cmd,
	input  logic [$clog2(STEPS+1)-1:0]     step_k,
	input  logic [pcbs_pkg::POINT_W-1:0]   point,
	output logic                           adv,
	output logic                           m_tvalid,
	input  logic                           m_tready,
	output logic [pcbs_pkg::POINT_W-1:0]   m_tdata,
	output logic                           m_tlast,
	output logic                           m_tuser
);

	localparam int CW  = pcbs_pkg::COORD_W;
	localparam int DGW = pcbs_pkg::DEG_W;
	localparam int SW  = $clog2(STEPS + 1);
	localparam int L1W = CW + SW;
	localparam int L2W = CW + 2 * SW;
	localparam int L3W = CW + 3 * SW;
	localparam int VW  = L3W + 1;

	localparam longint unsigned DEN     = longint'(STEPS) * STEPS * STEPS;
	localparam longint unsigned TWO_DEN = 2 * DEN;
	localparam int DW = $clog2(TWO_DEN + 1);
	// Scaled reciprocal of the doubled denominator, truncated.
	localparam longint unsigned RECIP = (longint'(1) << VW) / TWO_DEN;
	localparam int RW = $clog2(RECIP + 1);
	localparam int PW = VW + RW;
	localparam int MW = CW + DW;

	localparam logic [SW-1:0] STEPS_K   = SW'(STEPS);
	localparam logic [RW-1:0] RECIP_C   = RW'(RECIP);
	localparam logic [DW-1:0] TWO_DEN_C = DW'(TWO_DEN);
	localparam logic [VW-1:0] DEN_V     = VW'(DEN);

	// Point history and the control slots of the segment being sampled.
	logic [pcbs_pkg::POINT_W-1:0] hist_q [3];
	logic [CW-1:0]                slot_q [4][2];
	logic [DGW-1:0]               deg_q;

	logic [SW-1:0]  a_s0, b_s0;

	logic           vld_s1, vld_s2, vld_s3, vld_s4, vld_s5, out_vld_q;
	logic           last_s1, last_s2, last_s3, last_s4, last_s5, out_last_q;
	logic           done_s1, done_s2, done_s3, done_s4, done_s5, out_done_q;
	logic [SW-1:0]  a_s1, b_s1, a_s2, b_s2;
	logic [DGW-1:0] deg_s1, deg_s2;

	logic [L1W-1:0] lv1_d [3][2];
	logic [L1W-1:0] lv1_s1 [3][2];
	logic [L2W-1:0] lv2_d [2][2];
	logic [L2W-1:0] lv2_s2 [2][2];
	logic [L3W-1:0] num_d [2];
	logic [L3W-1:0] num_s3 [2];
	logic [VW-1:0]  v_d [2];
	logic [PW-1:0]  prod_d [2];
	logic [VW-1:0]  v_s4 [2];
	logic [CW-1:0]  qh_s4 [2];
	logic [MW-1:0]  m_d [2];
	logic [MW-1:0]  m_s5 [2];
	logic [VW-1:0]  v_s5 [2];
	logic [CW-1:0]  qh_s5 [2];
	logic [VW-1:0]  rem_d [2];
	logic [CW-1:0]  q_d [2];
	logic [CW-1:0]  out_q [2];

	assign adv  = !out_vld_q || m_tready;
	assign a_s0 = step_k;
	assign b_s0 = STEPS_K - step_k;

	always_ff @(posedge clk) begin
		if (cmd.push) begin
			hist_q[0] <= hist_q[1];
			hist_q[1] <= hist_q[2];
			hist_q[2] <= point;
		end
		if (cmd.load) begin
			deg_q <= cmd.degree;
			for (int c = 0; c < 2; c++) begin
				case (cmd.degree)
					2'd0: begin
						slot_q[0][c] <= point[c*CW +: CW];
						slot_q[1][c] <= point[c*CW +: CW];
						slot_q[2][c] <= point[c*CW +: CW];
					end
					2'd1: begin
						slot_q[0][c] <= hist_q[2][c*CW +: CW];
						slot_q[1][c] <= point[c*CW +: CW];
						slot_q[2][c] <= point[c*CW +: CW];
					end
					2'd2: begin
						slot_q[0][c] <= hist_q[1][c*CW +: CW];
						slot_q[1][c] <= hist_q[2][c*CW +: CW];
						slot_q[2][c] <= point[c*CW +: CW];
					end
					default: begin
						slot_q[0][c] <= hist_q[0][c*CW +: CW];
						slot_q[1][c] <= hist_q[1][c*CW +: CW];
						slot_q[2][c] <= hist_q[2][c*CW +: CW];
					end
				endcase
				slot_q[3][c] <= point[c*CW +: CW];
			end
		end
	end

	// De Casteljau levels in integer form; a level above the degree scales each entry of the level below by STEPS.
	always_comb begin
		for (int c = 0; c < 2; c++) begin
			for (int i = 0; i < 3; i++) begin
				lv1_d[i][c] = L1W'(b_s0) * L1W'(slot_q[i][c]) +
					L1W'(a_s0) * L1W'((deg_q != 2'd0) ? slot_q[i+1][c] : slot_q[i][c]);
			end
			for (int i = 0; i < 2; i++) begin
				lv2_d[i][c] = L2W'(b_s1) * L2W'(lv1_s1[i][c]) +
					L2W'(a_s1) * L2W'((deg_s1 >= 2'd2) ? lv1_s1[i+1][c] : lv1_s1[i][c]);
			end
			num_d[c] = L3W'(b_s2) * L3W'(lv2_s2[0][c]) +
				L3W'(a_s2) * L3W'((deg_s2 == pcbs_pkg::DEG_CUBIC) ? lv2_s2[1][c] : lv2_s2[0][c]);
			v_d[c]    = {num_s3[c], 1'b0} + DEN_V;
			prod_d[c] = PW'(v_d[c]) * PW'(RECIP_C);
			m_d[c]    = MW'(qh_s4[c]) * MW'(TWO_DEN_C);
			rem_d[c]  = v_s5[c] - VW'(m_s5[c]);
			q_d[c]    = (rem_d[c] >= VW'(TWO_DEN_C)) ? qh_s5[c] + 1'b1 : qh_s5[c];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			a_s1    <= a_s0;
			b_s1    <= b_s0;
			deg_s1  <= deg_q;
			last_s1 <= cmd.last;
			done_s1 <= cmd.done;
			a_s2    <= a_s1;
			b_s2    <= b_s1;
			deg_s2  <= deg_s1;
			last_s2 <= last_s1;
			done_s2 <= done_s1;
			last_s3 <= last_s2;
			done_s3 <= done_s2;
			last_s4 <= last_s3;
			done_s4 <= done_s3;
			last_s5 <= last_s4;
			done_s5 <= done_s4;
			out_last_q <= last_s5;
			out_done_q <= done_s5;
			lv1_s1 <= lv1_d;
			lv2_s2 <= lv2_d;
			for (int c = 0; c < 2; c++) begin
				num_s3[c] <= num_d[c];
				v_s4[c]   <= v_d[c];
				qh_s4[c]  <= prod_d[c][VW +: CW];
				m_s5[c]   <= m_d[c];
				v_s5[c]   <= v_s4[c];
				qh_s5[c]  <= qh_s4[c];
				out_q[c]  <= q_d[c];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1    <= 1'b0;
			vld_s2    <= 1'b0;
			vld_s3    <= 1'b0;
			vld_s4    <= 1'b0;
			vld_s5    <= 1'b0;
			out_vld_q <= 1'b0;
		end else if (adv) begin
			vld_s1    <= cmd.issue;
			vld_s2    <= vld_s1;
			vld_s3    <= vld_s2;
			vld_s4    <= vld_s3;
			vld_s5    <= vld_s4;
			out_vld_q <= vld_s5;
		end
	end

	assign m_tvalid = out_vld_q;
	assign m_tdata  = {out_q[1], out_q[0]};
	assign m_tlast  = out_last_q;
	assign m_tuser  = out_done_q;

endmodule

// File: sv/piecewise_cubic_bezier_sampler.sv
`timescale 1ns / 1ps

// Piecewise cubic Bezier sampler. Control points arrive one word at a time on the slave
// stream, with tlast on the last point of a curve. Points 0-3, 3-6, 6-9 and so on form
// cubic segments, and each segment is sampled at t = k/STEPS for k = 0..STEPS as its
// closing point arrives, giving STEPS+1 words on the master stream; tlast marks the last
// word caused by one point and tuser the last word of the whole curve. On the last point a
// longer curve whose segments do not close evenly gets a tail segment over its last four
// points, a curve of two or three points comes out as a line or a quadratic, and a curve
// of a single point comes out as that point. Each sample is the exact Bernstein sum
// rounded half up. Flow: a point that closes nothing is taken and the input stays open; a
// point that emits is taken, the input closes and the sample counter issues one sample per
// cycle while the master stream does not stall, so the block is ready again once the last
// sample of the segment is issued. The rate is set by that counter feeding one evaluation
// pipeline, and a stalled master stream holds the whole pipeline. The first word appears
// after the stage and output registers. No clearing pass is needed after reset.
module piecewise_cubic_bezier_sampler #(
	parameter int STEPS = pcbs_pkg::STEPS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         s_tvalid,
	output logic                         s_tready,
	// Fields from bit 0: point_x [11:0], point_y [23:12].
	input  logic [pcbs_pkg::POINT_W-1:0] s_tdata,
	input  logic                         s_tlast,
	output logic                         m_tvalid,
	input  logic                         m_tready,
	// Fields from bit 0: curve_x [11:0], curve_y [23:12].
	output logic [pcbs_pkg::POINT_W-1:0] m_tdata,
	output logic                         m_tlast,
	// Fields from bit 0: curve_done [0].
	output logic                         m_tuser
);

	// The controller decides from the point count and the index phase whether a word
	// closes a segment, and then drives the sample counter.
	pcbs_pkg::cmd_t               cmd;
	logic [$clog2(STEPS+1)-1:0]   step_k;
	logic                         adv;

	pcbs_ctrl #(
		.STEPS(STEPS)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tlast  (s_tlast),
		.s_tready (s_tready),
		.adv      (adv),
		.cmd      (cmd),
		.step_k   (step_k)
	);

	// The datapath keeps the point history, evaluates three integer de Casteljau levels
	// in three stages, then divides by STEPS cubed through a reciprocal multiply and a
	// one-step correction, and holds the finished word in the output register.
	pcbs_datapath #(
		.STEPS(STEPS)
	) u_datapath (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.step_k   (step_k),
		.point    (s_tdata),
		.adv      (adv),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast),
		.m_tuser  (m_tuser)
	);

endmodule

// File: sv/pcbs_checker.sv
`timescale 1ns / 1ps
`include "piecewise_cubic_bezier_sampler_macros.svh"

module pcbs_checker (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         s_tvalid,
	input logic                         s_tready,
	input logic                         s_tlast,
	input logic                         m_tvalid,
	input logic                         m_tready,
	input logic [pcbs_pkg::POINT_W-1:0] m_tdata,
	input logic                         m_tlast,
	input logic                         m_tuser
);

	// The end of a curve is always the end of the words of its last point.
	`PCBS_ASSERT(a_done_is_last, m_tvalid && m_tuser |-> m_tlast, "curve end without word end")

	// Every last point emits, so the input side closes right after it.
	`PCBS_ASSERT(a_final_busy, s_tvalid && s_tready && s_tlast |=> !s_tready, "ready after final point")

	// A stalled output word is held.
	`PCBS_ASSERT(a_out_hold, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata), "stalled word changed")

	// Nothing is offered while reset is applied.
	`PCBS_ASSERT_ALWAYS(a_reset_quiet, !arst_n |-> !m_tvalid, "output valid in reset")

endmodule

bind piecewise_cubic_bezier_sampler pcbs_checker u_pcbs_checker (.*);

// File: tb/tb.sv
`timescale 1ns / 1ps

// Self-checking bench for the piecewise cubic Bezier sampler.
module tb;
	import pcbs_pkg::*;

	localparam int STEPS         = STEPS_DEF;
	localparam int RANDOM_POINTS = 105;
	localparam int CYCLE_LIMIT   = 400000;
	// Idle margin after the final drain; the path from issue to the output register is well inside it.
	localparam int SETTLE_CYCLES = 20;
	localparam int REPORT_LIMIT  = 10;

	typedef logic [COORD_W-1:0] coord_t;
	typedef logic [POINT_W-1:0] point_t;
	typedef point_t ctrl_t [4];

	// One word on the master stream, with the fields in the order they are compared.
	typedef struct packed {
		coord_t x;
		coord_t y;
		logic   run_end;
		logic   curve_done;
	} sample_t;

	// Shapes of back-pressure that the receiver cycles through.
	typedef enum int {
		RX_OPEN,
		RX_LIGHT,
		RX_HEAVY,
		RX_PERIODIC
	} rx_mode_t;

	// The scoreboard keeps its own copy of the point history, so that every accepted
	// point can be turned into the samples that it should cause, in order.
	class curve_scoreboard;
		point_t             history [3];
		logic [SEEN_W-1:0]  seen;
		logic [PHASE_W-1:0] phase;
		sample_t            sample_q [$];
		int                 mismatches;
		int                 checked;

		function new();
			clear_curve();
			mismatches = 0;
			checked    = 0;
		endfunction

		function void clear_curve();
			history[0] = '0;
			history[1] = '0;
			history[2] = '0;
			seen       = '0;
			phase      = PHASE_ZERO;
		endfunction

		function longint unsigned power(longint unsigned base, int expo);
			longint unsigned acc;
			acc = 1;
			repeat (expo) acc = acc * base;
			return acc;
		endfunction

		// Exact Bernstein sum at t = k/STEPS, rounded half up.
		function coord_t bernstein(ctrl_t ctrl, int deg, int k, bit use_y);
			longint unsigned den;
			longint unsigned num;
			longint unsigned c;
			longint unsigned w;
			num = 0;
			den = power(STEPS, deg);
			for (int j = 0; j <= deg; j++) begin
				c = use_y ? ctrl[j][POINT_W-1:COORD_W] : ctrl[j][COORD_W-1:0];
				if (deg == 3 && (j == 1 || j == 2))
					w = 3;
				else if (deg == 2 && j == 1)
					w = 2;
				else
					w = 1;
				num += w * power(STEPS - k, deg - j) * power(k, j) * c;
			end
			return coord_t'((2 * num + den) / (2 * den));
		endfunction

		function void push_segment(ctrl_t ctrl, int deg, bit fin);
			sample_t s;
			for (int k = 0; k <= STEPS; k++) begin
				s.x          = bernstein(ctrl, deg, k, 1'b0);
				s.y          = bernstein(ctrl, deg, k, 1'b1);
				s.run_end    = (k == STEPS);
				s.curve_done = (k == STEPS) && fin;
				sample_q     = {sample_q, s};
			end
		endfunction

		function void note_point(coord_t px, coord_t py, bit fin);
			point_t  cur;
			ctrl_t   ctrl;
			sample_t s;
			int      deg;
			cur = {py, px};
			if (fin && seen == '0) begin
				// A lone point passes straight through.
				s = '{px, py, 1'b1, 1'b1};
				sample_q = {sample_q, s};
			end else if (fin && seen < SEEN_CUBIC) begin
				// Short curves come out as a line or a quadratic.
				deg = int'(seen);
				for (int j = 0; j < deg; j++)
					ctrl[j] = history[3 - deg + j];
				ctrl[deg] = cur;
				push_segment(ctrl, deg, 1'b1);
			end else if (seen >= SEEN_CUBIC && (phase == PHASE_ZERO || fin)) begin
				// A regular closing point, or the tail over the last four points.
				ctrl = '{history[0], history[1], history[2], cur};
				push_segment(ctrl, int'(DEG_CUBIC), fin);
			end
			if (fin) begin
				clear_curve();
			end else begin
				history[0] = history[1];
				history[1] = history[2];
				history[2] = cur;
				if (seen < SEEN_MAX)
					seen = seen + 1'b1;
				phase = (phase == PHASE_LAST) ? PHASE_ZERO : phase + 1'b1;
			end
		endfunction

		function void check_sample(sample_t got);
			sample_t want;
			checked++;
			if (sample_q.size() == 0) begin
				mismatches++;
				if (mismatches <= REPORT_LIMIT)
					$display("Unexpected word %0d: x=%0d y=%0d last=%0b done=%0b",
						checked, got.x, got.y, got.run_end, got.curve_done);
				return;
			end
			want = sample_q.pop_front();
			if (got.x !== want.x || got.y !== want.y || got.run_end !== want.run_end ||
					got.curve_done !== want.curve_done) begin
				mismatches++;
				if (mismatches <= REPORT_LIMIT)
					$display("Mismatch on word %0d: expected x=%0d y=%0d last=%0b done=%0b, got x=%0d y=%0d last=%0b done=%0b",
						checked, want.x, want.y, want.run_end, want.curve_done,
						got.x, got.y, got.run_end, got.curve_done);
			end
		endfunction

		function int pending();
			return sample_q.size();
		endfunction
	endclass

	logic   clk;
	logic   arst_n;
	logic   s_tvalid;
	logic   s_tready;
	point_t s_tdata;
	logic   s_tlast;
	logic   m_tvalid;
	logic   m_tready = 1'b0;
	point_t m_tdata;
	logic   m_tlast;
	logic   m_tuser;

	curve_scoreboard sb = new();

	int points_sent;
	int curves_sent;
	int burst_left;

	piecewise_cubic_bezier_sampler #(
		.STEPS(STEPS)
	) u_top (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata (s_tdata),
		.s_tlast (s_tlast),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata),
		.m_tlast (m_tlast),
		.m_tuser (m_tuser)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// The receiver holds one back-pressure shape for a random stretch of cycles
	// and then picks another, so that stalls land on every word of a segment, and the
	// open shape gives long stretches with no stall at all.
	rx_mode_t rx_mode = RX_OPEN;
	int       rx_left = 0;
	int       rx_tick = 0;

	always @(negedge clk) begin
		rx_tick <= rx_tick + 1;
		if (rx_left == 0) begin
			rx_mode <= rx_mode_t'($urandom_range(0, 3));
			rx_left <= $urandom_range(50, 300);
		end else begin
			rx_left <= rx_left - 1;
		end
		case (rx_mode)
			RX_OPEN:     m_tready <= 1'b1;
			RX_LIGHT:    m_tready <= ($urandom_range(0, 3) != 0);
			RX_HEAVY:    m_tready <= ($urandom_range(0, 9) < 3);
			RX_PERIODIC: m_tready <= ((rx_tick % 9) >= 3);
			default:     m_tready <= 1'b1;
		endcase
	end

	// Every word taken from the master stream is checked against the oldest sample
	// still waiting. The sampled values are those from just before the edge.
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready)
			sb.check_sample(sample_t'({m_tdata[COORD_W-1:0], m_tdata[POINT_W-1:COORD_W],
				m_tlast, m_tuser}));
	end

	// Offers one control point. The sender works in bursts: when a burst runs out it
	// idles for a random gap, putting noise on the data lines, before the next burst.
	// The point is handed to the scoreboard at the edge where it is accepted.
	task automatic send_point(coord_t px, coord_t py, bit fin);
		int gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
			repeat (gap) begin
				@(negedge clk);
				s_tvalid <= 1'b0;
				s_tdata  <= POINT_W'($urandom);
				s_tlast  <= 1'($urandom_range(0, 1));
			end
			burst_left = $urandom_range(1, 10);
		end
		burst_left--;
		@(negedge clk);
		s_tvalid <= 1'b1;
		s_tdata  <= {py, px};
		s_tlast  <= fin;
		do
			@(posedge clk);
		while (!s_tready);
		sb.note_point(px, py, fin);
		points_sent++;
		if (fin)
			curves_sent++;
	endtask

	// Drops the valid and holds off until every expected word has come back.
	task automatic drain();
		@(negedge clk);
		s_tvalid <= 1'b0;
		while (sb.pending() != 0)
			@(posedge clk);
	endtask

	// A coordinate that lands on an extreme with the given chance in percent.
	function automatic coord_t pick_coord(int corner_pct);
		if ($urandom_range(0, 99) < corner_pct)
			return ($urandom_range(0, 1) != 0) ? '1 : '0;
		return coord_t'($urandom_range(0, 4095));
	endfunction

	task automatic send_curve(int len, int corner_pct);
		for (int i = 0; i < len; i++)
			send_point(pick_coord(corner_pct), pick_coord(corner_pct), i == len - 1);
	endtask

	initial begin
		int directed;
		int sel;
		int len;
		arst_n      = 1'b0;
		s_tvalid    = 1'b0;
		s_tdata     = '0;
		s_tlast     = 1'b0;
		points_sent = 0;
		curves_sent = 0;
		burst_left  = 0;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Single-point curves at both extremes of the coordinate range.
		send_point('1, '1, 1'b1);
		send_point('0, '0, 1'b1);
		// A line and a quadratic between the corners.
		send_point('0, '1, 1'b0);
		send_point('1, '0, 1'b1);
		send_point('1, '0, 1'b0);
		send_point('0, '1, 1'b0);
		send_point('1, '1, 1'b1);
		// Four points: the last one closes a regular segment and no tail follows.
		send_point('0, '0, 1'b0);
		send_point('1, '1, 1'b0);
		send_point('0, '1, 1'b0);
		send_point('1, '0, 1'b1);
		// Five points: a segment on the fourth, then a tail over the last four.
		send_point('1, '0, 1'b0);
		send_point('0, '0, 1'b0);
		send_point('1, '1, 1'b0);
		send_point(12'h800, 12'h7FF, 1'b0);
		send_point('0, '1, 1'b1);
		// Six points: one segment, then a tail that overlaps it.
		send_curve(6, 50);
		directed = points_sent;

		// Let the pipeline run dry once before the random part starts.
		drain();

		// Random curves, mostly long enough to chain several segments, with the odd
		// short curve and the odd full drain in between.
		while (points_sent - directed < RANDOM_POINTS) begin
			sel = $urandom_range(0, 9);
			if (sel < 3)
				len = sel + 1;
			else
				len = $urandom_range(4, 13);
			send_curve(len, 15);
			if ($urandom_range(0, 7) == 0)
				drain();
		end

		drain();
		repeat (SETTLE_CYCLES) @(posedge clk);

		$display("Sent %0d control points in %0d curves (directed corner shapes, then random).",
			points_sent, curves_sent);
		$display("Checked %0d sampled words under varied back-pressure; %0d mismatched.",
			sb.checked, sb.mismatches);
		if (sb.mismatches == 0 && sb.pending() == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

	// Watchdog: a hung handshake ends the run here.
	initial begin
		repeat (CYCLE_LIMIT) @(posedge clk);
		$display("Timeout with %0d words still expected.", sb.pending());
		$display("Test completed with failures");
		$finish;
	end

endmodule

// File: filelist.f
+incdir+sv
sv/pcbs_pkg.sv
sv/pcbs_ctrl.sv
sv/pcbs_datapath.sv
sv/piecewise_cubic_bezier_sampler.sv
sv/pcbs_checker.sv
tb/tb.sv
